FILE: rtl/core/best_fit_block_allocator_core_defines.svh
// Assertion macros for the allocator core.
`ifndef BEST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define BEST_FIT_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// Same-cycle implication.
`define BFA_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication.
`define BFA_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

FILE: rtl/core/bfa_pkg.sv
package bfa_pkg;

   localparam int MAX_BLOCKS   = 32;
   localparam int OFFSET_BITS  = 16;
   localparam int HEADER_BYTES = 8;
   localparam int ALIGN_BYTES  = 8;
   localparam int ANCHOR_BYTES = 4;

   localparam int FIELD_W = 16;
   localparam int CALC_W  = 19;

   localparam logic [FIELD_W-1:0] REGION_RESET = 16'd4096;
   localparam logic [FIELD_W-1:0] OFF_MASK =
      FIELD_W'((64'd1 << OFFSET_BITS) - 64'd1);
   localparam int FIRST_DATA =
      ((ANCHOR_BYTES + HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;

   localparam logic [1:0] CMD_INIT     = 2'd0;
   localparam logic [1:0] CMD_ALLOCATE = 2'd1;
   localparam logic [1:0] CMD_FREE     = 2'd2;
   localparam logic [1:0] CMD_RESIZE   = 2'd3;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_NOSPACE = 2'd1;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd2;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_START_A,
      OP_INIT,
      OP_SCAN_A,
      OP_START_B,
      OP_SCAN_B,
      OP_CHECK,
      OP_REM_T,
      OP_REM_PRE,
      OP_REM_FOL,
      OP_JOIN,
      OP_SPLIT,
      OP_PUSH_S,
      OP_PUSH_T,
      OP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic       scan_done;
      logic       found;
      logic       fail;
   } dp_stat_type;

   function automatic logic [CALC_W-1:0] round_up(input logic [CALC_W-1:0] a);
      return ((a + CALC_W'(ALIGN_BYTES - 1)) / CALC_W'(ALIGN_BYTES)) * CALC_W'(ALIGN_BYTES);
   endfunction

endpackage

FILE: rtl/core/bfa_req_if.sv
interface bfa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] block_offset;
   logic [15:0] request_bytes;

   modport source (output valid, cmd, block_offset, request_bytes, input ready);
   modport sink (input valid, cmd, block_offset, request_bytes, output ready);
endinterface

FILE: rtl/core/bfa_rsp_if.sv
interface bfa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [15:0] data_offset;
   logic        content_moved;
   logic [15:0] move_source;
   logic [15:0] move_bytes;

   modport source (output valid, status, data_offset, content_moved, move_source, move_bytes,
                   input ready);
   modport sink (input valid, status, data_offset, content_moved, move_source, move_bytes,
                 output ready);
endinterface

FILE: rtl/core/bfa_ram.sv
module bfa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/core/bfa_ctrl.sv
module bfa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [1:0]           req_cmd,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bfa_pkg::dp_cmd_type  dp_cmd,
   input  bfa_pkg::dp_stat_type dp_stat
);

   typedef enum logic [13:0] {
      S_IDLE    = 14'b00000000000001,
      S_INIT    = 14'b00000000000010,
      S_SCAN_A  = 14'b00000000000100,
      S_START_B = 14'b00000000001000,
      S_SCAN_B  = 14'b00000000010000,
      S_CHECK   = 14'b00000000100000,
      S_REM_T   = 14'b00000001000000,
      S_REM_PRE = 14'b00000010000000,
      S_REM_FOL = 14'b00000100000000,
      S_JOIN    = 14'b00001000000000,
      S_SPLIT   = 14'b00010000000000,
      S_PUSH_S  = 14'b00100000000000,
      S_PUSH_T  = 14'b01000000000000,
      S_DONE    = 14'b10000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      load;

   always_comb begin
      state_in  = state_ff;
      dp_cmd.op = bfa_pkg::OP_NONE;
      load      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.op = bfa_pkg::OP_START_A;
               state_in  = (req_cmd == bfa_pkg::CMD_INIT) ? S_INIT : S_SCAN_A;
            end
         end
         S_INIT: begin
            dp_cmd.op = bfa_pkg::OP_INIT;
            state_in  = S_DONE;
         end
         S_SCAN_A: begin
            dp_cmd.op = bfa_pkg::OP_SCAN_A;
            if (dp_stat.scan_done) begin
               if (!dp_stat.found) begin
                  state_in = S_DONE;
               end else if (dp_stat.cmd == bfa_pkg::CMD_ALLOCATE) begin
                  state_in = S_REM_T;
               end else begin
                  state_in = S_START_B;
               end
            end
         end
         S_START_B: begin
            dp_cmd.op = bfa_pkg::OP_START_B;
            state_in  = S_SCAN_B;
         end
         S_SCAN_B: begin
            dp_cmd.op = bfa_pkg::OP_SCAN_B;
            if (dp_stat.scan_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            dp_cmd.op = bfa_pkg::OP_CHECK;
            if (dp_stat.cmd == bfa_pkg::CMD_RESIZE && dp_stat.fail) begin
               state_in = S_DONE;
            end else begin
               state_in = S_REM_PRE;
            end
         end
         S_REM_T: begin
            dp_cmd.op = bfa_pkg::OP_REM_T;
            state_in  = S_JOIN;
         end
         S_REM_PRE: begin
            dp_cmd.op = bfa_pkg::OP_REM_PRE;
            state_in  = S_REM_FOL;
         end
         S_REM_FOL: begin
            dp_cmd.op = bfa_pkg::OP_REM_FOL;
            state_in  = S_JOIN;
         end
         S_JOIN: begin
            dp_cmd.op = bfa_pkg::OP_JOIN;
            state_in  = S_SPLIT;
         end
         S_SPLIT: begin
            dp_cmd.op = bfa_pkg::OP_SPLIT;
            state_in  = (dp_stat.cmd == bfa_pkg::CMD_FREE) ? S_PUSH_T : S_PUSH_S;
         end
         S_PUSH_S: begin
            dp_cmd.op = bfa_pkg::OP_PUSH_S;
            state_in  = S_DONE;
         end
         S_PUSH_T: begin
            dp_cmd.op = bfa_pkg::OP_PUSH_T;
            state_in  = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               dp_cmd.op = bfa_pkg::OP_LOAD;
               load      = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/core/bfa_dp.sv
module bfa_dp #(
   parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [15:0]          csr_data,
   input  logic [1:0]           req_cmd,
   input  logic [15:0]          req_block_offset,
   input  logic [15:0]          req_request_bytes,
   input  bfa_pkg::dp_cmd_type  dp_cmd,
   output bfa_pkg::dp_stat_type dp_stat,
   output logic [1:0]           rsp_status,
   output logic [15:0]          rsp_data_offset,
   output logic                 rsp_content_moved,
   output logic [15:0]          rsp_move_source,
   output logic [15:0]          rsp_move_bytes
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam int FW = bfa_pkg::FIELD_W;
   localparam int AW = bfa_pkg::CALC_W;
   localparam logic [AW-1:0] HDR_C = AW'(bfa_pkg::HEADER_BYTES);
   localparam logic [FW-1:0] FIRST_C = FW'(bfa_pkg::FIRST_DATA);
   localparam logic [FW-1:0] FIRST_HDR = FW'(bfa_pkg::FIRST_DATA - bfa_pkg::HEADER_BYTES);

   logic [MAX_BLOCKS-1:0] in_use_ff, is_free_ff;
   logic [IW-1:0]         rank_ff [MAX_BLOCKS];
   logic [FW-1:0]         region_ff;

   logic [1:0]    cmd_ff;
   logic [FW-1:0] off_ff, req_ff;
   logic [CW-1:0] cnt_ff;
   logic          rd_v_ff;
   logic [IW-1:0] rd_idx_ff;
   logic          found_ff;
   logic [IW-1:0] t_idx_ff, t_rank_ff, i_idx_ff;
   logic [FW-1:0] t_hdr_ff, t_size_ff, i_hdr_ff, i_size_ff;
   logic          pre_ok_ff, fol_ok_ff;
   logic [IW-1:0] pre_idx_ff, pre_rank_ff, fol_idx_ff, fol_rank_ff;
   logic [FW-1:0] pre_hdr_ff, pre_size_ff, fol_size_ff;
   logic          fu_ok_ff, s_ok_ff, fail_ff, split_ff;
   logic [IW-1:0] fu_idx_ff, s_idx_ff;
   logic [FW-1:0] s_hdr_ff, s_size_ff;
   logic [AW-1:0] tot_ff;

   logic [1:0]    status_ff;
   logic [FW-1:0] data_off_ff, msrc_ff, mbytes_ff;
   logic          moved_ff;

   logic          ram_we;
   logic [IW-1:0] ram_waddr;
   logic [2*FW-1:0] ram_wdata, ram_rdata;

   bfa_ram #(
      .WIDTH (2 * FW),
      .DEPTH (MAX_BLOCKS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (cnt_ff[IW-1:0]),
      .rdata (ram_rdata)
   );

   logic [FW-1:0] e_hdr, e_size;
   logic          e_use, e_free;
   logic [IW-1:0] e_rank;
   logic [AW-1:0] e_data, e_end, i_data, i_end;
   logic          scan_step, scan_a, scan_b;

   assign e_hdr     = ram_rdata[2*FW-1:FW];
   assign e_size    = ram_rdata[FW-1:0];
   assign e_use     = in_use_ff[rd_idx_ff];
   assign e_free    = is_free_ff[rd_idx_ff];
   assign e_rank    = rank_ff[rd_idx_ff];
   assign e_data    = AW'(e_hdr) + HDR_C;
   assign e_end     = e_data + AW'(e_size);
   assign i_data    = AW'(i_hdr_ff) + HDR_C;
   assign i_end     = i_data + AW'(i_size_ff);
   assign scan_a    = (dp_cmd.op == bfa_pkg::OP_SCAN_A);
   assign scan_b    = (dp_cmd.op == bfa_pkg::OP_SCAN_B);
   assign scan_step = scan_a || scan_b;

   logic [AW-1:0] tot_calc;
   assign tot_calc = AW'(i_size_ff)
                   + (pre_ok_ff ? AW'(pre_size_ff) + HDR_C : '0)
                   + (fol_ok_ff ? AW'(fol_size_ff) + HDR_C : '0);

   logic [AW-1:0] t_data, t_end, sp_start;
   logic          split_ok;
   assign t_data   = AW'(t_hdr_ff) + HDR_C;
   assign t_end    = t_data + AW'(t_size_ff);
   assign sp_start = bfa_pkg::round_up(t_data + AW'(req_ff) + HDR_C);
   assign split_ok = (cmd_ff != bfa_pkg::CMD_FREE) && (sp_start <= t_end) && s_ok_ff;

   logic          s_ok_c;
   logic [IW-1:0] s_idx_c;
   always_comb begin
      s_ok_c  = fu_ok_ff;
      s_idx_c = fu_idx_ff;
      if (fol_ok_ff && (!s_ok_c || fol_idx_ff < s_idx_c)) begin
         s_ok_c  = 1'b1;
         s_idx_c = fol_idx_ff;
      end
      if (pre_ok_ff && (!s_ok_c || i_idx_ff < s_idx_c)) begin
         s_ok_c  = 1'b1;
         s_idx_c = i_idx_ff;
      end
   end

   logic          rem_en, push_en;
   logic [IW-1:0] rem_x, rem_r, push_x;
   always_comb begin
      rem_en  = 1'b0;
      rem_x   = t_idx_ff;
      rem_r   = t_rank_ff;
      push_en = 1'b0;
      push_x  = t_idx_ff;
      case (dp_cmd.op)
         bfa_pkg::OP_REM_T: begin
            rem_en = 1'b1;
         end
         bfa_pkg::OP_REM_PRE: begin
            rem_en = pre_ok_ff;
            rem_x  = pre_idx_ff;
            rem_r  = pre_rank_ff;
         end
         bfa_pkg::OP_REM_FOL: begin
            rem_en = fol_ok_ff;
            rem_x  = fol_idx_ff;
            rem_r  = fol_rank_ff;
         end
         bfa_pkg::OP_PUSH_S: begin
            push_en = split_ff;
            push_x  = s_idx_ff;
         end
         bfa_pkg::OP_PUSH_T: begin
            push_en = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = t_idx_ff;
      ram_wdata = {t_hdr_ff, t_size_ff};
      case (dp_cmd.op)
         bfa_pkg::OP_INIT: begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = {FIRST_HDR, (region_ff > FIRST_C) ? region_ff - FIRST_C : FW'(0)};
         end
         bfa_pkg::OP_SPLIT: begin
            ram_we    = 1'b1;
            ram_wdata = {t_hdr_ff, split_ok ? FW'(sp_start - HDR_C - t_data) : t_size_ff};
         end
         bfa_pkg::OP_PUSH_S: begin
            ram_we    = split_ff;
            ram_waddr = s_idx_ff;
            ram_wdata = {s_hdr_ff, s_size_ff};
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff <= bfa_pkg::REGION_RESET;
      end else if (csr_valid) begin
         region_ff <= csr_data;
      end
   end

   // free-list table
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         is_free_ff <= '0;
      end else begin
         if (dp_cmd.op == bfa_pkg::OP_INIT) begin
            in_use_ff     <= MAX_BLOCKS'(1);
            is_free_ff    <= MAX_BLOCKS'(1);
            rank_ff[0]    <= '0;
         end
         if (rem_en) begin
            for (int j = 0; j < MAX_BLOCKS; j++) begin
               if (in_use_ff[j] && is_free_ff[j] && rank_ff[j] > rem_r) begin
                  rank_ff[j] <= rank_ff[j] - IW'(1);
               end
            end
            is_free_ff[rem_x] <= 1'b0;
            rank_ff[rem_x]    <= '0;
         end
         if (push_en) begin
            for (int j = 0; j < MAX_BLOCKS; j++) begin
               if (in_use_ff[j] && is_free_ff[j]) begin
                  rank_ff[j] <= rank_ff[j] + IW'(1);
               end
            end
            in_use_ff[push_x]  <= 1'b1;
            is_free_ff[push_x] <= 1'b1;
            rank_ff[push_x]    <= '0;
         end
         if (dp_cmd.op == bfa_pkg::OP_JOIN) begin
            if (fol_ok_ff) begin
               in_use_ff[fol_idx_ff] <= 1'b0;
            end
            if (pre_ok_ff) begin
               in_use_ff[i_idx_ff] <= 1'b0;
            end
         end
      end
   end

   // scan and working registers
   always_ff @(posedge clock) begin
      if (dp_cmd.op == bfa_pkg::OP_START_A) begin
         cmd_ff    <= req_cmd;
         off_ff    <= req_block_offset;
         req_ff    <= req_request_bytes;
         found_ff  <= 1'b0;
         fu_ok_ff  <= 1'b0;
         pre_ok_ff <= 1'b0;
         fol_ok_ff <= 1'b0;
         fail_ff   <= 1'b0;
         split_ff  <= 1'b0;
      end
      if (dp_cmd.op == bfa_pkg::OP_START_A || dp_cmd.op == bfa_pkg::OP_START_B) begin
         cnt_ff  <= '0;
         rd_v_ff <= 1'b0;
      end
      if (scan_step) begin
         if (cnt_ff != CW'(MAX_BLOCKS)) begin
            cnt_ff    <= cnt_ff + CW'(1);
            rd_v_ff   <= 1'b1;
            rd_idx_ff <= cnt_ff[IW-1:0];
         end else begin
            rd_v_ff <= 1'b0;
         end
         if (rd_v_ff && !e_use && !fu_ok_ff) begin
            fu_ok_ff  <= 1'b1;
            fu_idx_ff <= rd_idx_ff;
         end
      end
      if (scan_a && rd_v_ff && e_use) begin
         if (cmd_ff == bfa_pkg::CMD_ALLOCATE) begin
            if (e_free && e_size >= req_ff &&
                (!found_ff || e_size < t_size_ff ||
                 (e_size == t_size_ff && e_rank < t_rank_ff))) begin
               found_ff  <= 1'b1;
               t_idx_ff  <= rd_idx_ff;
               t_hdr_ff  <= e_hdr;
               t_size_ff <= e_size;
               t_rank_ff <= e_rank;
            end
         end else if (!e_free && !found_ff && e_data == AW'(off_ff)) begin
            found_ff  <= 1'b1;
            i_idx_ff  <= rd_idx_ff;
            i_hdr_ff  <= e_hdr;
            i_size_ff <= e_size;
         end
      end
      if (scan_b && rd_v_ff && e_use && e_free) begin
         if (e_end == AW'(i_hdr_ff)) begin
            pre_ok_ff   <= 1'b1;
            pre_idx_ff  <= rd_idx_ff;
            pre_hdr_ff  <= e_hdr;
            pre_size_ff <= e_size;
            pre_rank_ff <= e_rank;
         end
         if (i_end == AW'(e_hdr)) begin
            fol_ok_ff   <= 1'b1;
            fol_idx_ff  <= rd_idx_ff;
            fol_size_ff <= e_size;
            fol_rank_ff <= e_rank;
         end
      end
      if (dp_cmd.op == bfa_pkg::OP_CHECK) begin
         tot_ff  <= tot_calc;
         fail_ff <= (cmd_ff == bfa_pkg::CMD_RESIZE) && (tot_calc < AW'(req_ff));
      end
      if (dp_cmd.op == bfa_pkg::OP_REM_PRE && pre_ok_ff && fol_ok_ff &&
          fol_rank_ff > pre_rank_ff) begin
         fol_rank_ff <= fol_rank_ff - IW'(1);
      end
      if (dp_cmd.op == bfa_pkg::OP_JOIN) begin
         s_ok_ff  <= s_ok_c;
         s_idx_ff <= s_idx_c;
         if (cmd_ff != bfa_pkg::CMD_ALLOCATE) begin
            t_idx_ff  <= pre_ok_ff ? pre_idx_ff : i_idx_ff;
            t_hdr_ff  <= pre_ok_ff ? pre_hdr_ff : i_hdr_ff;
            t_size_ff <= FW'(tot_ff);
         end
      end
      if (dp_cmd.op == bfa_pkg::OP_SPLIT) begin
         split_ff  <= split_ok;
         s_hdr_ff  <= FW'(sp_start - HDR_C);
         s_size_ff <= FW'(t_end - sp_start);
      end
   end

   logic [1:0] status_c;
   always_comb begin
      case (cmd_ff)
         bfa_pkg::CMD_ALLOCATE: status_c = found_ff ? bfa_pkg::STATUS_OK
                                                    : bfa_pkg::STATUS_NOSPACE;
         bfa_pkg::CMD_FREE: status_c = (off_ff == '0 || found_ff) ? bfa_pkg::STATUS_OK
                                                                 : bfa_pkg::STATUS_UNKNOWN;
         bfa_pkg::CMD_RESIZE: status_c = !found_ff ? bfa_pkg::STATUS_UNKNOWN
                                       : fail_ff ? bfa_pkg::STATUS_NOSPACE
                                                 : bfa_pkg::STATUS_OK;
         default: status_c = bfa_pkg::STATUS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.op == bfa_pkg::OP_LOAD) begin
         status_ff   <= status_c;
         data_off_ff <= '0;
         moved_ff    <= 1'b0;
         msrc_ff     <= '0;
         mbytes_ff   <= '0;
         if (status_c == bfa_pkg::STATUS_OK &&
             (cmd_ff == bfa_pkg::CMD_ALLOCATE || cmd_ff == bfa_pkg::CMD_RESIZE)) begin
            data_off_ff <= FW'(t_data) & bfa_pkg::OFF_MASK;
         end
         if (status_c == bfa_pkg::STATUS_OK && cmd_ff == bfa_pkg::CMD_RESIZE && pre_ok_ff) begin
            moved_ff  <= 1'b1;
            msrc_ff   <= off_ff & bfa_pkg::OFF_MASK;
            mbytes_ff <= (i_size_ff < req_ff) ? i_size_ff : req_ff;
         end
      end
   end

   assign dp_stat.cmd       = cmd_ff;
   assign dp_stat.scan_done = (cnt_ff == CW'(MAX_BLOCKS)) && !rd_v_ff;
   assign dp_stat.found     = found_ff;
   assign dp_stat.fail      = (tot_calc < AW'(req_ff));

   assign rsp_status        = status_ff;
   assign rsp_data_offset   = data_off_ff;
   assign rsp_content_moved = moved_ff;
   assign rsp_move_source   = msrc_ff;
   assign rsp_move_bytes    = mbytes_ff;

endmodule

FILE: rtl/core/best_fit_block_allocator_core.sv
// Flow: init writes the first block; allocate scans the table once, free and resize
// scan it twice, and a miss or a failed resize ends the item early.
// Throughput: one item at a time; the next is taken the cycle after the result loads,
// and a held result stalls the input. Each scan walks one entry a cycle
// through the single read port of the header/size memory.
// Reset: synchronous; empties the table (no block until init), region_bytes to 4096.
`include "best_fit_block_allocator_core_defines.svh"

module best_fit_block_allocator_core #(
   parameter int MAX_BLOCKS = bfa_pkg::MAX_BLOCKS
) (
   input  logic         clock,
   input  logic         reset,
   bfa_req_if.sink      req_ch,
   bfa_rsp_if.source    rsp_ch,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [15:0]  csr_data
);

   bfa_pkg::dp_cmd_type  dp_cmd;
   bfa_pkg::dp_stat_type dp_stat;

   assign csr_ready = 1'b1;

   bfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_cmd   (req_ch.cmd),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   bfa_dp #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_data          (csr_data),
      .req_cmd           (req_ch.cmd),
      .req_block_offset  (req_ch.block_offset),
      .req_request_bytes (req_ch.request_bytes),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .rsp_status        (rsp_ch.status),
      .rsp_data_offset   (rsp_ch.data_offset),
      .rsp_content_moved (rsp_ch.content_moved),
      .rsp_move_source   (rsp_ch.move_source),
      .rsp_move_bytes    (rsp_ch.move_bytes)
   );

   `BFA_ASSERT_IMPL(a_nospace_no_offset, rsp_ch.valid && rsp_ch.status == bfa_pkg::STATUS_NOSPACE, rsp_ch.data_offset == '0)
   `BFA_ASSERT_IMPL(a_move_only_ok, rsp_ch.valid && rsp_ch.content_moved, rsp_ch.status == bfa_pkg::STATUS_OK)
   `BFA_ASSERT_NEXT(a_one_item, req_ch.valid && req_ch.ready, !req_ch.ready)

endmodule

FILE: tb/tb_best_fit_block_allocator_core.sv
module tb_best_fit_block_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NB = bfa_pkg::MAX_BLOCKS;
   localparam int SETTLE = 200;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] data_offset;
      logic        content_moved;
      logic [15:0] move_source;
      logic [15:0] move_bytes;
   } alloc_result_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_valid;
   logic csr_ready;
   logic [15:0] csr_data;

   bfa_req_if req_ch();
   bfa_rsp_if rsp_ch();

   best_fit_block_allocator_core u_dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // allocator shadow
   logic [15:0] region_size;
   int unsigned blk_hdr[NB];
   int unsigned blk_len[NB];
   bit          blk_used[NB];
   bit          blk_free[NB];
   int unsigned blk_rank[NB];

   alloc_result_type pending_results[$];
   int mismatches = 0;
   int stall_left = 0;
   bit no_idle = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("FAILURE");
      $finish;
   end

   function automatic int unsigned align_up(int unsigned a);
      return ((a + bfa_pkg::ALIGN_BYTES - 1) / bfa_pkg::ALIGN_BYTES) * bfa_pkg::ALIGN_BYTES;
   endfunction

   function automatic void wipe_table();
      for (int i = 0; i < NB; i++) begin
         blk_hdr[i] = 0; blk_len[i] = 0; blk_used[i] = 0; blk_free[i] = 0; blk_rank[i] = 0;
      end
   endfunction

   function automatic void unlink_free(int i);
      int unsigned r;
      r = blk_rank[i];
      blk_free[i] = 0;
      blk_rank[i] = 0;
      for (int j = 0; j < NB; j++)
         if (blk_used[j] && blk_free[j] && blk_rank[j] > r) blk_rank[j]--;
   endfunction

   function automatic void link_free(int i);
      for (int j = 0; j < NB; j++)
         if (blk_used[j] && blk_free[j]) blk_rank[j]++;
      blk_free[i] = 1;
      blk_rank[i] = 0;
   endfunction

   function automatic int lookup_busy(int unsigned off);
      for (int i = 0; i < NB; i++)
         if (blk_used[i] && !blk_free[i] && blk_hdr[i] + bfa_pkg::HEADER_BYTES == off)
            return i;
      return -1;
   endfunction

   function automatic int smallest_fit(int unsigned want);
      int b;
      b = -1;
      for (int i = 0; i < NB; i++) begin
         if (!blk_used[i] || !blk_free[i] || blk_len[i] < want) continue;
         if (b < 0 || blk_len[i] < blk_len[b] ||
             (blk_len[i] == blk_len[b] && blk_rank[i] < blk_rank[b])) b = i;
      end
      return b;
   endfunction

   function automatic void carve_tail(int i, int unsigned want);
      int unsigned dstart, dend, nstart;
      int s;
      dstart = blk_hdr[i] + bfa_pkg::HEADER_BYTES;
      dend = dstart + blk_len[i];
      nstart = align_up(dstart + want + bfa_pkg::HEADER_BYTES);
      if (nstart > dend) return;
      s = -1;
      for (int k = NB - 1; k >= 0; k--)
         if (!blk_used[k]) s = k;
      if (s < 0) return;
      blk_len[i] = nstart - bfa_pkg::HEADER_BYTES - dstart;
      blk_used[s] = 1;
      blk_hdr[s] = nstart - bfa_pkg::HEADER_BYTES;
      blk_len[s] = dend - nstart;
      blk_free[s] = 0;
      link_free(s);
   endfunction

   function automatic void find_adjacent(int i, output int pre, output int fol);
      pre = -1;
      fol = -1;
      for (int j = 0; j < NB; j++) begin
         if (!blk_used[j] || !blk_free[j]) continue;
         if (blk_hdr[j] + bfa_pkg::HEADER_BYTES + blk_len[j] == blk_hdr[i]) pre = j;
         if (blk_hdr[i] + bfa_pkg::HEADER_BYTES + blk_len[i] == blk_hdr[j]) fol = j;
      end
   endfunction

   function automatic int merge_blocks(int i, int pre, int fol);
      if (fol >= 0) begin
         blk_len[i] += bfa_pkg::HEADER_BYTES + blk_len[fol];
         blk_used[fol] = 0; blk_len[fol] = 0; blk_hdr[fol] = 0;
      end
      if (pre >= 0) begin
         blk_len[pre] += bfa_pkg::HEADER_BYTES + blk_len[i];
         blk_used[i] = 0; blk_len[i] = 0; blk_hdr[i] = 0;
         return pre;
      end
      return i;
   endfunction

   function automatic alloc_result_type apply_command(logic [1:0] cmd, logic [15:0] off,
                                                      logic [15:0] want);
      alloc_result_type r;
      int i, t, pre, fol;
      int unsigned d0, old, spare;
      r = '0;
      case (cmd)
         bfa_pkg::CMD_INIT: begin
            d0 = align_up(bfa_pkg::ANCHOR_BYTES + bfa_pkg::HEADER_BYTES);
            wipe_table();
            blk_used[0] = 1;
            blk_free[0] = 1;
            blk_hdr[0] = d0 - bfa_pkg::HEADER_BYTES;
            blk_len[0] = region_size > d0 ? region_size - d0 : 0;
         end
         bfa_pkg::CMD_ALLOCATE: begin
            t = smallest_fit(want);
            if (t < 0) begin
               r.status = bfa_pkg::STATUS_NOSPACE;
            end else begin
               unlink_free(t);
               carve_tail(t, want);
               r.data_offset = 16'(blk_hdr[t] + bfa_pkg::HEADER_BYTES);
            end
         end
         bfa_pkg::CMD_FREE: begin
            if (off != 0) begin
               i = lookup_busy(off);
               if (i < 0) begin
                  r.status = bfa_pkg::STATUS_UNKNOWN;
               end else begin
                  find_adjacent(i, pre, fol);
                  if (pre >= 0) unlink_free(pre);
                  if (fol >= 0) unlink_free(fol);
                  t = merge_blocks(i, pre, fol);
                  link_free(t);
               end
            end
         end
         default: begin
            i = (off != 0) ? lookup_busy(off) : -1;
            if (i < 0) begin
               r.status = bfa_pkg::STATUS_UNKNOWN;
            end else begin
               old = blk_len[i];
               spare = 0;
               find_adjacent(i, pre, fol);
               if (pre >= 0) spare += bfa_pkg::HEADER_BYTES + blk_len[pre];
               if (fol >= 0) spare += bfa_pkg::HEADER_BYTES + blk_len[fol];
               if (old + spare < want) begin
                  r.status = bfa_pkg::STATUS_NOSPACE;
               end else begin
                  if (pre >= 0) unlink_free(pre);
                  if (fol >= 0) unlink_free(fol);
                  t = merge_blocks(i, pre, fol);
                  if (pre >= 0) begin
                     r.content_moved = 1;
                     r.move_source = off;
                     r.move_bytes = 16'(old < want ? old : want);
                  end
                  carve_tail(t, want);
                  r.data_offset = 16'(blk_hdr[t] + bfa_pkg::HEADER_BYTES);
               end
            end
         end
      endcase
      return r;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic logic [15:0] live_offset();
      int idx[$];
      for (int i = 0; i < NB; i++)
         if (blk_used[i] && !blk_free[i]) idx.push_back(i);
      if (idx.size() == 0) return 16'(bfa_pkg::FIRST_DATA);
      return 16'(blk_hdr[idx[$urandom_range(0, idx.size() - 1)]] + bfa_pkg::HEADER_BYTES);
   endfunction

   // response side: compare, then decide ready for the next edge
   always @(posedge clock) begin
      alloc_result_type got, want;
      int g;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = '{rsp_ch.status, rsp_ch.data_offset, rsp_ch.content_moved,
                 rsp_ch.move_source, rsp_ch.move_bytes};
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 0;
      end else begin
         g = pick_gap();
         rsp_ch.ready <= (g == 0) || ($urandom_range(0, 3) == 0);
      end
   end

   task automatic send_item(logic [1:0] cmd, logic [15:0] off, logic [15:0] want);
      int g;
      g = pick_gap();
      if (g > 0) begin
         req_ch.valid <= 0;
         repeat (g) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.cmd <= cmd;
      req_ch.block_offset <= off;
      req_ch.request_bytes <= want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_results.push_back(apply_command(cmd, off, want));
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_region(logic [15:0] v);
      drain();
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      region_size = v;
      csr_valid <= 0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 16'($urandom_range(0, 200));
      if (r < 95) return 16'($urandom_range(0, 3000));
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic send_random();
      int r;
      logic [15:0] off;
      r = $urandom_range(0, 99);
      if (r < 2) begin
         send_item(bfa_pkg::CMD_INIT, 16'($urandom_range(0, 65535)),
                   16'($urandom_range(0, 65535)));
         return;
      end
      r = $urandom_range(0, 99);
      if (r < 75) off = live_offset();
      else if (r < 85) off = 0;
      else off = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 45) send_item(bfa_pkg::CMD_ALLOCATE, 16'($urandom_range(0, 65535)), rand_size());
      else if (r < 75) send_item(bfa_pkg::CMD_FREE, off, 16'($urandom_range(0, 65535)));
      else send_item(bfa_pkg::CMD_RESIZE, off, rand_size());
   endtask

   task automatic run_random(int n);
      for (int k = 0; k < n; k++) begin
         if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
         send_random();
      end
      no_idle = 0;
   endtask

   task automatic test_before_init();
      send_item(bfa_pkg::CMD_ALLOCATE, 0, 0);
      send_item(bfa_pkg::CMD_FREE, 0, 0);
      send_item(bfa_pkg::CMD_FREE, 16'd16, 0);
      send_item(bfa_pkg::CMD_RESIZE, 0, 16'd8);
      send_item(bfa_pkg::CMD_RESIZE, 16'd16, 16'd8);
   endtask

   task automatic test_directed();
      logic [15:0] a, b;
      send_item(bfa_pkg::CMD_INIT, 0, 0);
      send_item(bfa_pkg::CMD_ALLOCATE, 0, 16'hFFFF);
      send_item(bfa_pkg::CMD_ALLOCATE, 0, 0);
      send_item(bfa_pkg::CMD_ALLOCATE, 16'hFFFF, 16'd1);
      a = live_offset();
      send_item(bfa_pkg::CMD_ALLOCATE, 0, 16'd40);
      send_item(bfa_pkg::CMD_ALLOCATE, 0, 16'd40);
      b = live_offset();
      send_item(bfa_pkg::CMD_FREE, 16'd3, 0);
      send_item(bfa_pkg::CMD_FREE, a, 0);
      send_item(bfa_pkg::CMD_FREE, a, 0);
      send_item(bfa_pkg::CMD_RESIZE, b, 16'd100);
      send_item(bfa_pkg::CMD_RESIZE, live_offset(), 16'hFFFF);
      send_item(bfa_pkg::CMD_RESIZE, live_offset(), 16'd0);
      send_item(bfa_pkg::CMD_ALLOCATE, 0, 16'd4000);
      send_item(bfa_pkg::CMD_FREE, live_offset(), 0);
      send_item(bfa_pkg::CMD_RESIZE, 16'hFFFF, 16'd8);
   endtask

   task automatic test_fill_table();
      send_item(bfa_pkg::CMD_INIT, 0, 0);
      for (int k = 0; k < 40; k++)
         send_item(bfa_pkg::CMD_ALLOCATE, 0, 16'($urandom_range(0, 16)));
      for (int k = 0; k < 30; k++) send_random();
   endtask

   task automatic test_region_settings();
      logic [15:0] sizes[4];
      sizes = '{16'd32, 16'd65535, 16'd33 + 16'($urandom_range(0, 500)), 16'd4096};
      foreach (sizes[k]) begin
         write_region(sizes[k]);
         send_item(bfa_pkg::CMD_INIT, 0, 0);
         run_random(120);
      end
   endtask

   task automatic test_backpressure();
      stall_left = 500;
      send_item(bfa_pkg::CMD_INIT, 0, 0);
      for (int k = 0; k < 40; k++) send_random();
   endtask

   task automatic test_random_mix();
      send_item(bfa_pkg::CMD_INIT, 0, 0);
      run_random(920);
   endtask

   initial begin
      req_ch.valid = 0;
      req_ch.cmd = bfa_pkg::CMD_INIT;
      req_ch.block_offset = 0;
      req_ch.request_bytes = 0;
      rsp_ch.ready = 0;
      csr_valid = 0;
      csr_data = 0;
      region_size = bfa_pkg::REGION_RESET;
      wipe_table();
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_before_init();
      test_directed();
      test_fill_table();
      test_region_settings();
      test_backpressure();
      test_random_mix();
      drain();
      if (mismatches == 0 && pending_results.size() == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
